// File: rtl/kws_pkg.sv
// Package for the kernel window smoother: sizes, register codes and the
// structs passed between the pipeline modules. Depends on nothing.
package kws_pkg;

  localparam int WIN              = 5;
  localparam int HALF             = WIN / 2;
  localparam int TAPS             = WIN * WIN;
  localparam int LINES            = WIN - 1;
  localparam int MAX_WIDTH        = 1024;
  localparam int SAMPLE_BITS      = 16;
  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int FW_W    = 11;
  localparam int FH_W    = 16;
  localparam int ROW_W   = FH_W + 1;
  localparam int TOT_W   = FW_W + FH_W;
  localparam int POS_W   = ROW_W + FW_W;
  localparam int OCNT_W  = 26;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;
  localparam int SEL_W   = 5;

  localparam int TAP_W    = SAMPLE_BITS + 1;
  localparam int LINE_W   = LINES * TAP_W;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = SAMPLE_BITS + WEIGHT_W;
  localparam int SUM_BITS = $clog2(TAPS);
  localparam int ROWSUM_W = PROD_W + $clog2(WIN);
  localparam int ROWW_W   = WEIGHT_W + $clog2(WIN);
  localparam int ACC_W    = PROD_W + SUM_BITS;
  localparam int WSUM_W   = WEIGHT_W + SUM_BITS;
  localparam int NUM_W    = ACC_W + 2;
  localparam int DEN_W    = WSUM_W + 1;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = SAMPLE_BITS / DIV_STEPS;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_NORMALISE,
    REG_WEIGHT_SELECT,
    REG_WEIGHT_VALUE
  } cfg_reg_e;

  typedef logic [TAP_W-1:0] tap_t;
  typedef tap_t [TAPS-1:0] window_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [TAPS-1:0] weights_t;

  typedef struct packed {
    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [TOT_W-1:0] total;
    logic [POS_W-1:0] thr;
  } geom_t;

  typedef struct packed {
    logic           valid;
    logic           last;
    logic [WIN-1:0] rowok;
    logic [WIN-1:0] colok;
  } win_meta_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     centre;
    logic signed [ACC_W-1:0]  acc;
    logic signed [WSUM_W-1:0] wsum;
  } sum_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smoothed;
    logic                   result_valid;
    logic                   frame_end;
  } result_t;

endpackage

// File: rtl/kernel_window_smoother.sv
// Top level of the 5x5 weighted window smoother: configuration registers,
// pipeline enable and the four pipeline parts. Depends on kws_pkg.
//
// Usage: pixels enter in raster order on sample/location_valid/pad, a
// transfer being pixel_valid high with pixel_stall low. After the frame,
// pad items flush the window; the result for pixel q leaves on the item
// with raster index q + 2*width + 2. Results leave on smoothed,
// result_valid and frame_end as filtered_valid high with filtered_stall low.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high, tap weights are loaded by writing weight_select
// then weight_value.
// Throughput is one item per cycle while pixel_stall is low. A result is
// presented once the item that completes its window has passed the stages:
// five stages of line memory, window and multiply-accumulate, nine of the
// radix-4 divider, one of the output queue.
// After reset the line memory is cleared one column per cycle, with
// pixel_stall held high. When the receiver stalls, the two-entry output
// queue fills; a further result halts the pipeline, raising pixel_stall.
module kernel_window_smoother (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [kws_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   location_valid,
  input  logic                                   pad,
  input  logic                                   pixel_valid,
  output logic                                   pixel_stall,
  output logic signed [kws_pkg::SAMPLE_BITS-1:0] smoothed,
  output logic                                   result_valid,
  output logic                                   frame_end,
  output logic                                   filtered_valid,
  input  logic                                   filtered_stall,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kws_pkg::IDX_W-1:0]              cfg_index,
  input  logic [kws_pkg::DATA_W-1:0]             cfg_data
);
  import kws_pkg::*;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic             normalise;
  logic [SEL_W-1:0] weight_select;
  weights_t         tap_weights;

  geom_t            geom;
  logic [FW_W-1:0]  w_cl;
  logic [FH_W-1:0]  h_cl;
  logic             en, accept, clearing, div_valid, q_full;
  window_t          window;
  win_meta_t        meta;
  sum_t             sum;
  result_t          div_res, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_W'(MAX_WIDTH);
      frame_height  <= FH_W'(1);
      normalise     <= 1'b0;
      weight_select <= '0;
      tap_weights   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[FH_W-1:0];
        REG_NORMALISE:     normalise     <= cfg_data[0];
        REG_WEIGHT_SELECT: weight_select <= cfg_data[SEL_W-1:0];
        REG_WEIGHT_VALUE: begin
          if (32'(weight_select) < TAPS) begin
            tap_weights[weight_select] <= cfg_data[WEIGHT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_cl = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_cl = FW_W'(MAX_WIDTH);
    end else begin
      w_cl = frame_width;
    end
    h_cl       = (frame_height == '0) ? FH_W'(1) : frame_height;
    geom.w     = w_cl;
    geom.h     = h_cl;
    geom.total = TOT_W'(w_cl) * TOT_W'(h_cl);
    geom.thr   = POS_W'(HALF) * POS_W'(w_cl) + POS_W'(HALF);
  end

  // the pipeline halts only when a result has nowhere to go
  assign en          = !(div_valid && q_full);
  assign pixel_stall = !en || clearing;
  assign accept      = pixel_valid && !pixel_stall;

  kws_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .accept         (accept),
    .geom           (geom),
    .sample         (sample),
    .location_valid (location_valid),
    .pad            (pad),
    .window         (window),
    .meta           (meta),
    .clearing       (clearing)
  );

  kws_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .window  (window),
    .meta    (meta),
    .weights (tap_weights),
    .sum     (sum)
  );

  kws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .normalise (normalise),
    .sum       (sum),
    .res_valid (div_valid),
    .res       (div_res)
  );

  kws_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (div_valid && en),
    .din   (div_res),
    .stall (filtered_stall),
    .valid (filtered_valid),
    .dout  (q_out),
    .full  (q_full)
  );

  assign smoothed     = q_out.smoothed;
  assign result_valid = q_out.result_valid;
  assign frame_end    = q_out.frame_end;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> pixel_stall)
    else $error("pixel taken during line memory clear");

  a_frozen_result_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(div_res))
    else $error("divider output moved while pipeline halted");

  a_stall_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> pixel_stall)
    else $error("input open straight after reset");

endmodule

// File: rtl/kws_front.sv
// Front end: raster counters, line memory with read-modify-write shift and
// the window registers. Depends on kws_pkg.
module kws_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  accept,
  input  kws_pkg::geom_t                        geom,
  input  logic signed [kws_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  location_valid,
  input  logic                                  pad,
  output kws_pkg::window_t                      window,
  output kws_pkg::win_meta_t                    meta,
  output logic                                  clearing
);
  import kws_pkg::*;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [OCNT_W-1:0] ocnt;
  logic [COL_W-1:0]  qcol;
  logic [FH_W-1:0]   qrow;

  logic              ignore, in_image, emit, last;
  logic [COL_W-1:0]  c0;
  logic [POS_W-1:0]  pos;
  tap_t              item;
  logic [TOT_W-1:0]  ocnt_inc;
  logic [FW_W-1:0]   col_inc, qcol_inc;
  logic [WIN-1:0]    rowok, colok;

  // stage 1
  logic              v1, e1, l1;
  logic [COL_W-1:0]  a1;
  tap_t              item1;
  logic [WIN-1:0]    rowok1, colok1;

  logic [LINE_W-1:0] lines [MAX_WIDTH];
  logic [LINE_W-1:0] rd, old, wr_data;
  logic              fwd_valid;
  logic [COL_W-1:0]  fwd_addr;
  logic [LINE_W-1:0] fwd_data;
  logic [COL_W:0]    clr_cnt;

  assign clearing = !clr_cnt[COL_W];

  always_comb begin
    logic [FH_W:0]  tr;
    logic [COL_W:0] tc;
    ignore   = pad && (col == '0) && (row == '0) && (ocnt == '0);
    c0       = ({1'b0, col} >= geom.w) ? '0 : col;
    pos      = POS_W'(row) * POS_W'(geom.w) + POS_W'(c0);
    in_image = pos < POS_W'(geom.total);
    item     = (in_image && !pad) ? {location_valid, sample} : '0;
    emit     = pos >= geom.thr;
    ocnt_inc = TOT_W'(ocnt) + TOT_W'(1);
    last     = emit && (ocnt_inc >= geom.total);
    col_inc  = FW_W'(c0) + FW_W'(1);
    qcol_inc = FW_W'(qcol) + FW_W'(1);
    // in-image masks for the window of the output pixel
    for (int k = 0; k < WIN; k++) begin
      tr = (FH_W+1)'(qrow) + (FH_W+1)'(k);
      rowok[k] = (tr >= (FH_W+1)'(HALF)) &&
                 ((tr - (FH_W+1)'(HALF)) < (FH_W+1)'(geom.h));
      tc = (COL_W+1)'(qcol) + (COL_W+1)'(k);
      colok[k] = (tc >= (COL_W+1)'(HALF)) && ((tc - (COL_W+1)'(HALF)) < geom.w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      ocnt <= '0;
      qcol <= '0;
      qrow <= '0;
    end else if (accept && !ignore) begin
      if (last) begin
        col  <= '0;
        row  <= '0;
        ocnt <= '0;
        qcol <= '0;
        qrow <= '0;
      end else begin
        if (col_inc >= geom.w) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col_inc[COL_W-1:0];
        end
        if (emit) begin
          ocnt <= ocnt + OCNT_W'(1);
          if (qcol_inc >= geom.w) begin
            qcol <= '0;
            qrow <= qrow + FH_W'(1);
          end else begin
            qcol <= qcol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept && !ignore;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1     <= emit;
      l1     <= last;
      a1     <= c0;
      item1  <= item;
      rowok1 <= rowok;
      colok1 <= colok;
    end
  end

  // line memory: one entry per column holds the four older rows
  always_ff @(posedge clk) begin
    if (en) begin
      rd <= lines[c0];
    end
    if (clearing) begin
      lines[clr_cnt[COL_W-1:0]] <= '0;
    end else if (en && v1) begin
      lines[a1] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + (COL_W+1)'(1);
    end
  end

  // the write made in the same cycle as the read is not seen by it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (en && v1) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1) begin
      fwd_addr <= a1;
      fwd_data <= wr_data;
    end
  end

  assign old     = (fwd_valid && (fwd_addr == a1)) ? fwd_data : rd;
  assign wr_data = {item1, old[LINE_W-1:TAP_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (en && v1) begin
      for (int k = 0; k < WIN; k++) begin
        for (int l = 0; l < WIN - 1; l++) begin
          window[k*WIN+l] <= window[k*WIN+l+1];
        end
      end
      for (int k = 0; k < LINES; k++) begin
        window[k*WIN+WIN-1] <= old[k*TAP_W +: TAP_W];
      end
      window[LINES*WIN+WIN-1] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta.valid <= 1'b0;
    end else if (en) begin
      meta.valid <= v1 && e1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta.last  <= l1;
      meta.rowok <= rowok1;
      meta.colok <= colok1;
    end
  end

endmodule

// File: rtl/kws_mac.sv
// Multiply-accumulate over the window: tap products, row sums, total.
// Three register stages. Depends on kws_pkg.
module kws_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  kws_pkg::window_t    window,
  input  kws_pkg::win_meta_t  meta,
  input  kws_pkg::weights_t   weights,
  output kws_pkg::sum_t       sum
);
  import kws_pkg::*;

  logic signed [PROD_W-1:0]   prod_c [TAPS];
  logic signed [WEIGHT_W-1:0] wm_c   [TAPS];
  logic signed [PROD_W-1:0]   prod3  [TAPS];
  logic signed [WEIGHT_W-1:0] wm3    [TAPS];
  logic                       v3, l3, c3;

  logic signed [ROWSUM_W-1:0] rs_c [WIN];
  logic signed [ROWW_W-1:0]   rw_c [WIN];
  logic signed [ROWSUM_W-1:0] rs4  [WIN];
  logic signed [ROWW_W-1:0]   rw4  [WIN];
  logic                       v4, l4, c4;

  logic signed [ACC_W-1:0]    acc_c;
  logic signed [WSUM_W-1:0]   wsum_c;

  always_comb begin
    logic inimg;
    for (int t = 0; t < TAPS; t++) begin
      inimg = meta.rowok[t/WIN] && meta.colok[t%WIN];
      prod_c[t] = inimg ? PROD_W'($signed(window[t][SAMPLE_BITS-1:0])) * PROD_W'(weights[t])
                        : '0;
      wm_c[t]   = inimg ? weights[t] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      sum.valid <= 1'b0;
    end else if (en) begin
      v3 <= meta.valid;
      v4 <= v3;
      sum.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < TAPS; t++) begin
        prod3[t] <= prod_c[t];
        wm3[t]   <= wm_c[t];
      end
      l3 <= meta.last;
      c3 <= window[HALF*WIN+HALF][SAMPLE_BITS];
    end
  end

  always_comb begin
    logic signed [ROWSUM_W-1:0] a;
    logic signed [ROWW_W-1:0]   b;
    for (int r = 0; r < WIN; r++) begin
      a = '0;
      b = '0;
      for (int l = 0; l < WIN; l++) begin
        a = a + ROWSUM_W'(prod3[r*WIN+l]);
        b = b + ROWW_W'(wm3[r*WIN+l]);
      end
      rs_c[r] = a;
      rw_c[r] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < WIN; r++) begin
        rs4[r] <= rs_c[r];
        rw4[r] <= rw_c[r];
      end
      l4 <= l3;
      c4 <= c3;
    end
  end

  always_comb begin
    acc_c  = '0;
    wsum_c = '0;
    for (int r = 0; r < WIN; r++) begin
      acc_c  = acc_c + ACC_W'(rs4[r]);
      wsum_c = wsum_c + WSUM_W'(rw4[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum.last   <= l4;
      sum.centre <= c4;
      sum.acc    <= acc_c;
      sum.wsum   <= wsum_c;
    end
  end

endmodule

// File: rtl/kws_div.sv
// Rounding divider: setup stage, then two quotient bits per stage, with
// saturation to the sample width. Plain mode divides by the unit weight.
// Depends on kws_pkg.
module kws_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              normalise,
  input  kws_pkg::sum_t     sum,
  output logic              res_valid,
  output kws_pkg::result_t  res
);
  import kws_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]       rem;
    logic [SAMPLE_BITS-1:0] q;
  } div_state_t;

  logic                   neg_acc, wneg, sat0, ok0, neg0;
  logic [ACC_W-1:0]       mag;
  logic [WSUM_W-1:0]      wmag, dsel;
  logic [NUM_W-1:0]       num;
  logic [DEN_W-1:0]       den;

  logic                   dv   [DIV_STAGES+1];
  logic                   dl   [DIV_STAGES+1];
  logic                   dok  [DIV_STAGES+1];
  logic                   dneg [DIV_STAGES+1];
  logic                   dsat [DIV_STAGES+1];
  logic [DEN_W-1:0]       dden [DIV_STAGES+1];
  div_state_t             dst  [DIV_STAGES+1];
  div_state_t             nst  [1:DIV_STAGES];

  logic [SAMPLE_BITS-1:0] qf;
  logic                   big;

  // numerator 2|acc|+d over 2d gives round half away from zero
  always_comb begin
    neg_acc = sum.acc[ACC_W-1];
    mag     = neg_acc ? ACC_W'(-sum.acc) : ACC_W'(sum.acc);
    wneg    = sum.wsum[WSUM_W-1];
    wmag    = wneg ? WSUM_W'(-sum.wsum) : WSUM_W'(sum.wsum);
    dsel    = normalise ? wmag : WSUM_W'(1 << WEIGHT_FRAC_BITS);
    num     = (NUM_W'(mag) << 1) + NUM_W'(dsel);
    den     = {dsel, 1'b0};
    sat0    = num >= (NUM_W'(den) << SAMPLE_BITS);
    ok0     = sum.centre && (!normalise || (sum.wsum != '0));
    neg0    = neg_acc ^ (normalise && wneg);
  end

  always_comb begin
    div_state_t  st;
    logic [NUM_W-1:0] ds;
    int          bitpos;
    for (int j = 1; j <= DIV_STAGES; j++) begin
      st = dst[j-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        bitpos = SAMPLE_BITS - 1 - (j - 1) * DIV_STEPS - s;
        ds = NUM_W'(dden[j-1]) << bitpos;
        if (st.rem >= ds) begin
          st.rem = st.rem - ds;
          st.q[bitpos] = 1'b1;
        end
      end
      nst[j] = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DIV_STAGES; j++) begin
        dv[j] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= sum.valid;
      for (int j = 1; j <= DIV_STAGES; j++) begin
        dv[j] <= dv[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0]   <= sum.last;
      dok[0]  <= ok0;
      dneg[0] <= neg0;
      dsat[0] <= sat0;
      dden[0] <= den;
      dst[0]  <= '{rem: (sat0 ? '0 : num), q: '0};
      for (int j = 1; j <= DIV_STAGES; j++) begin
        dl[j]   <= dl[j-1];
        dok[j]  <= dok[j-1];
        dneg[j] <= dneg[j-1];
        dsat[j] <= dsat[j-1];
        dden[j] <= dden[j-1];
        dst[j]  <= nst[j];
      end
    end
  end

  always_comb begin
    qf  = dst[DIV_STAGES].q;
    big = dsat[DIV_STAGES] || qf[SAMPLE_BITS-1];
    if (!dok[DIV_STAGES]) begin
      res.smoothed = '0;
    end else if (dneg[DIV_STAGES]) begin
      res.smoothed = big ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : SAMPLE_BITS'(-qf);
    end else begin
      res.smoothed = big ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : qf;
    end
    res.result_valid = dok[DIV_STAGES];
    res.frame_end    = dl[DIV_STAGES];
    res_valid        = dv[DIV_STAGES];
  end

endmodule

// File: rtl/kws_outq.sv
// Two-entry output queue that parts the pipeline from the receiver's stall.
// Depends on kws_pkg.
module kws_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kws_pkg::result_t  din,
  input  logic              stall,
  output logic              valid,
  output kws_pkg::result_t  dout,
  output logic              full
);
  import kws_pkg::*;

  result_t    entries [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       pop;

  assign valid = cnt != 2'd0;
  assign full  = cnt == 2'd2;
  assign pop   = valid && !stall;
  assign dout  = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= din;
    end
  end

endmodule
